>>> hw/rtl/rups_pkg.sv
// Shared constants, types and helpers for the range update / power sum engine.
package rups_pkg;

    localparam int ARRAY_SIZE = 4096;
    localparam int ADDR_W = $clog2(ARRAY_SIZE);
    localparam int IDX_W = 13;
    localparam int VAL_W = 14;
    localparam int MODULUS = 10007;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(ARRAY_SIZE - 1);
    localparam logic [IDX_W-1:0] ARRAY_LIMIT = IDX_W'(ARRAY_SIZE);
    localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(4096);
    localparam logic [VAL_W-1:0] MOD_VAL = VAL_W'(MODULUS);

    localparam int MM_W = 27;
    localparam int PROD_W = 2 * MM_W;
    localparam int RECIP_SHIFT = 40;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(MODULUS);
    localparam logic [MM_W-1:0] RECIP = RECIP_FULL[MM_W-1:0];

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_MUL = 2'd1;
    localparam logic [1:0] MODE_SET = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic [1:0] POW_ONE = 2'd1;
    localparam logic [1:0] POW_TWO = 2'd2;
    localparam logic [1:0] POW_THREE = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_WAIT1,
        ST_WAIT2
    } eng_state_t;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_RCP,
        MM_BACK,
        MM_FIX
    } mm_phase_t;

    function automatic logic [VAL_W-1:0] mod_fold(input logic [VAL_W:0] v);
        logic [VAL_W:0] r;
        begin
            r = v;
            if (v >= {1'b0, MOD_VAL})
            begin
                r = v - {1'b0, MOD_VAL};
            end
            mod_fold = r[VAL_W-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/range_update_power_sum_engine.sv
// Top level: element memory, range sequencer and result register.
// After reset the block clears its 4096-entry memory, one entry per cycle, and holds busy high
// while it clears; configuration writes are taken at any time. A request walks its range
// one element at a time through a single-port memory and one shared modular multiplier: each
// element is read, then add, assign and first-power query finish in the execute state, while
// multiply and second-power query wait for one multiplier pass and third-power query for two.
// A request with a bad range or power is dropped at once; for a query its error result shows
// in the next cycle. A query result appears on result_strobe for exactly one cycle, the cycle
// after the last element; the receiver cannot stall it.
module range_update_power_sum_engine
    import rups_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       mode,
    input  logic [IDX_W-1:0] range_left,
    input  logic [IDX_W-1:0] range_right,
    input  logic [VAL_W-1:0] operand,
    output logic             result_strobe,
    output logic [VAL_W-1:0] power_sum,
    output logic             bad_range,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_data
);

    eng_state_t state_reg, state_next;
    logic [IDX_W-1:0] element_count_reg;
    logic [ADDR_W-1:0] addr_reg, last_reg;
    logic [1:0] mode_reg;
    logic [VAL_W-1:0] c_reg, sum_reg, rd_data_reg;
    logic result_strobe_reg, bad_range_reg;
    logic [VAL_W-1:0] power_sum_reg;

    logic [VAL_W-1:0] mem_array [ARRAY_SIZE];

    logic accept, range_ok, pow_ok, item_ok;
    logic [IDX_W-1:0] left_m1, right_m1;
    logic [VAL_W-1:0] opnd_red;
    logic mem_we;
    logic [VAL_W-1:0] mem_wdata;
    logic mm_go, mm_done;
    logic [VAL_W-1:0] mm_a, mm_b, mm_result;
    logic acc_en, elem_done, last_elem;
    logic [VAL_W-1:0] term, sum_new, add_val;

    rups_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mm_go),
        .a      (mm_a),
        .b      (mm_b),
        .done   (mm_done),
        .result (mm_result)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign range_ok = (range_left != '0) && (range_left <= range_right)
        && (range_right <= element_count_reg) && (range_right <= ARRAY_LIMIT);
    assign pow_ok = (operand == VAL_W'(POW_ONE)) || (operand == VAL_W'(POW_TWO))
        || (operand == VAL_W'(POW_THREE));
    assign item_ok = range_ok && ((mode != MODE_QUERY) || pow_ok);
    assign left_m1 = range_left - IDX_W'(1);
    assign right_m1 = range_right - IDX_W'(1);
    assign opnd_red = mod_fold({1'b0, operand});
    assign last_elem = (addr_reg == last_reg);
    assign add_val = mod_fold({1'b0, rd_data_reg} + {1'b0, c_reg});
    assign sum_new = mod_fold({1'b0, sum_reg} + {1'b0, term});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (addr_reg == ADDR_LAST) state_next = ST_IDLE;
            ST_IDLE:  if (accept && item_ok) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC,
            ST_WAIT1,
            ST_WAIT2:
            begin
                if (elem_done)
                begin
                    state_next = last_elem ? ST_IDLE : ST_READ;
                end
                else if (mm_go)
                begin
                    state_next = (state_reg == ST_EXEC) ? ST_WAIT1 : ST_WAIT2;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wdata = '0;
        mm_go = 1'b0;
        mm_a = rd_data_reg;
        mm_b = c_reg;
        term = rd_data_reg;
        acc_en = 1'b0;
        elem_done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_ADD:
                    begin
                        mem_we = 1'b1;
                        mem_wdata = add_val;
                        elem_done = 1'b1;
                    end
                    MODE_MUL:
                    begin
                        mm_go = 1'b1;
                    end
                    MODE_SET:
                    begin
                        mem_we = 1'b1;
                        mem_wdata = c_reg;
                        elem_done = 1'b1;
                    end
                    default:
                    begin
                        if (c_reg[1:0] == POW_ONE)
                        begin
                            acc_en = 1'b1;
                            elem_done = 1'b1;
                        end
                        else
                        begin
                            mm_go = 1'b1;
                            mm_b = rd_data_reg;
                        end
                    end
                endcase
            end
            ST_WAIT1:
            begin
                if (mm_done)
                begin
                    if (mode_reg == MODE_MUL)
                    begin
                        mem_we = 1'b1;
                        mem_wdata = mm_result;
                        elem_done = 1'b1;
                    end
                    else if (c_reg[1:0] == POW_THREE)
                    begin
                        mm_go = 1'b1;
                        mm_a = mm_result;
                        mm_b = rd_data_reg;
                    end
                    else
                    begin
                        term = mm_result;
                        acc_en = 1'b1;
                        elem_done = 1'b1;
                    end
                end
            end
            ST_WAIT2:
            begin
                if (mm_done)
                begin
                    term = mm_result;
                    acc_en = 1'b1;
                    elem_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg <= '0;
            element_count_reg <= COUNT_RESET;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_strobe_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                element_count_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            else if (accept)
            begin
                addr_reg <= left_m1[ADDR_W-1:0];
            end
            else if (elem_done && !last_elem)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            if (accept && (mode == MODE_QUERY) && !item_ok)
            begin
                result_strobe_reg <= 1'b1;
            end
            else if (elem_done && last_elem && (mode_reg == MODE_QUERY))
            begin
                result_strobe_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            c_reg <= opnd_red;
            last_reg <= right_m1[ADDR_W-1:0];
            sum_reg <= '0;
        end
        else if (acc_en)
        begin
            sum_reg <= sum_new;
        end
        if (accept && (mode == MODE_QUERY) && !item_ok)
        begin
            power_sum_reg <= '0;
            bad_range_reg <= 1'b1;
        end
        else if (elem_done && last_elem && (mode_reg == MODE_QUERY))
        begin
            power_sum_reg <= sum_new;
            bad_range_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[addr_reg] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem_array[addr_reg];
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_strobe = result_strobe_reg;
    assign power_sum = power_sum_reg;
    assign bad_range = bad_range_reg;

    a_error_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe_reg && bad_range_reg) |-> power_sum_reg == '0)
        else $error("error result with nonzero sum");

    a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe_reg |-> power_sum_reg < MOD_VAL)
        else $error("power sum not reduced");

    a_good_request_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_ok) |=> state_reg == ST_READ)
        else $error("valid request did not start its walk");

endmodule

>>> hw/rtl/rups_mulmod.sv
// Multi-cycle modular multiplier built around one shared multiplier.
module rups_mulmod
    import rups_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    output logic             done,
    output logic [VAL_W-1:0] result
);

    mm_phase_t phase_reg, phase_next;
    logic [MM_W-1:0] p_reg;
    logic [VAL_W-1:0] q_reg;
    logic [VAL_W:0] d_reg;
    logic [VAL_W-1:0] result_reg;
    logic done_reg;

    logic [MM_W-1:0] x_sel, y_sel;
    logic [PROD_W-1:0] prod;
    logic [MM_W-1:0] diff_full;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            MM_IDLE: if (go) phase_next = MM_RCP;
            MM_RCP:  phase_next = MM_BACK;
            MM_BACK: phase_next = MM_FIX;
            MM_FIX:  phase_next = MM_IDLE;
            default: phase_next = MM_IDLE;
        endcase
    end

    always_comb
    begin
        x_sel = MM_W'(a);
        y_sel = MM_W'(b);
        case (phase_reg)
            MM_RCP:
            begin
                x_sel = p_reg;
                y_sel = RECIP;
            end
            MM_BACK:
            begin
                x_sel = MM_W'(q_reg);
                y_sel = MM_W'(MOD_VAL);
            end
            default:
            begin
                x_sel = MM_W'(a);
                y_sel = MM_W'(b);
            end
        endcase
    end

    assign prod = x_sel * y_sel;
    assign diff_full = p_reg - prod[MM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MM_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg <= (phase_reg == MM_FIX);
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            MM_IDLE: if (go) p_reg <= prod[MM_W-1:0];
            MM_RCP:  q_reg <= prod[RECIP_SHIFT +: VAL_W];
            MM_BACK: d_reg <= diff_full[VAL_W:0];
            MM_FIX:  result_reg <= mod_fold(d_reg);
            default: ;
        endcase
    end

    assign done = done_reg;
    assign result = result_reg;

    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> phase_reg == MM_IDLE)
        else $error("multiplier started while busy");

    a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(phase_reg) == MM_FIX)
        else $error("done without final phase");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> result_reg < MOD_VAL)
        else $error("result not reduced");

endmodule

>>> tb/tb_range_update_power_sum_engine.sv
// Self-checking testbench for the range update / power sum engine: directed table, then random.
module tb_range_update_power_sum_engine
    import rups_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]       mode;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [VAL_W-1:0] operand;
        bit               typed;
        logic [VAL_W-1:0] exp_sum;
        logic             exp_bad;
    } request_row_t;

    typedef struct {
        logic [VAL_W-1:0] power_sum;
        logic             bad_range;
    } query_result_t;

    localparam int N_DIRECTED = 24;
    localparam int N_PHASES = 6;

    request_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{MODE_QUERY, 13'd1,    13'd4096, 14'd1,     1'b1, 14'd0, 1'b0},
        '{MODE_QUERY, 13'd1,    13'd4096, 14'd3,     1'b1, 14'd0, 1'b0},
        '{MODE_SET,   13'd1,    13'd4096, 14'd16383, 1'b0, 14'd0, 1'b0},
        '{MODE_QUERY, 13'd4096, 13'd4096, 14'd3,     1'b0, 14'd0, 1'b0},
        '{MODE_ADD,   13'd1,    13'd8,    14'd10006, 1'b0, 14'd0, 1'b0},
        '{MODE_MUL,   13'd3,    13'd6,    14'd10007, 1'b0, 14'd0, 1'b0},
        '{MODE_MUL,   13'd1,    13'd4096, 14'd2,     1'b0, 14'd0, 1'b0},
        '{MODE_QUERY, 13'd1,    13'd4096, 14'd2,     1'b0, 14'd0, 1'b0},
        '{MODE_QUERY, 13'd0,    13'd5,    14'd1,     1'b1, 14'd0, 1'b1},
        '{MODE_QUERY, 13'd9,    13'd8,    14'd1,     1'b1, 14'd0, 1'b1},
        '{MODE_QUERY, 13'd1,    13'd4097, 14'd1,     1'b1, 14'd0, 1'b1},
        '{MODE_QUERY, 13'd8191, 13'd8191, 14'd1,     1'b1, 14'd0, 1'b1},
        '{MODE_QUERY, 13'd1,    13'd8191, 14'd2,     1'b1, 14'd0, 1'b1},
        '{MODE_QUERY, 13'd1,    13'd4,    14'd0,     1'b1, 14'd0, 1'b1},
        '{MODE_QUERY, 13'd1,    13'd4,    14'd4,     1'b1, 14'd0, 1'b1},
        '{MODE_QUERY, 13'd1,    13'd4,    14'd16383, 1'b1, 14'd0, 1'b1},
        '{MODE_ADD,   13'd0,    13'd3,    14'd5,     1'b0, 14'd0, 1'b0},
        '{MODE_SET,   13'd5,    13'd4,    14'd7,     1'b0, 14'd0, 1'b0},
        '{MODE_ADD,   13'd4090, 13'd4096, 14'd16383, 1'b0, 14'd0, 1'b0},
        '{MODE_QUERY, 13'd4090, 13'd4096, 14'd1,     1'b0, 14'd0, 1'b0},
        '{MODE_SET,   13'd10,   13'd20,   14'd0,     1'b0, 14'd0, 1'b0},
        '{MODE_QUERY, 13'd1,    13'd30,   14'd3,     1'b0, 14'd0, 1'b0},
        '{MODE_MUL,   13'd1,    13'd30,   14'd9999,  1'b0, 14'd0, 1'b0},
        '{MODE_QUERY, 13'd1,    13'd30,   14'd2,     1'b0, 14'd0, 1'b0}
    };

    logic [IDX_W-1:0] phase_counts [0:N_PHASES-1] = '{
        13'd1, 13'd0, 13'd37, 13'd2000, 13'd4096, 13'd4095
    };
    int phase_items [0:N_PHASES-1] = '{20, 6, 22, 22, 22, 24};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       mode;
    logic [IDX_W-1:0] range_left;
    logic [IDX_W-1:0] range_right;
    logic [VAL_W-1:0] operand;
    logic             result_strobe;
    logic [VAL_W-1:0] power_sum;
    logic             bad_range;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_data;

    logic [VAL_W-1:0] element_model [0:ARRAY_SIZE-1];
    logic [IDX_W-1:0] count_model;
    query_result_t    pending_sums [$];
    query_result_t    oldest_sum;

    int failures = 0;
    int updates_sent = 0;
    int queries_sent = 0;
    int results_checked = 0;
    int count_writes = 0;
    int burst_left = 0;

    range_update_power_sum_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .range_left    (range_left),
        .range_right   (range_right),
        .operand       (operand),
        .result_strobe (result_strobe),
        .power_sum     (power_sum),
        .bad_range     (bad_range),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned active_limit();
        return (count_model > ARRAY_SIZE) ? ARRAY_SIZE : int'(count_model);
    endfunction

    function automatic bit range_ok(logic [IDX_W-1:0] left, logic [IDX_W-1:0] right);
        return left >= 1 && left <= right && right <= active_limit();
    endfunction

    function automatic int unsigned residue_power(int unsigned v, int unsigned p);
        int unsigned acc;
        acc = v;
        for (int unsigned k = 1; k < p; k++)
            acc = (acc * v) % MODULUS;
        return acc;
    endfunction

    function automatic query_result_t power_sum_of(request_row_t r);
        query_result_t res;
        int unsigned   sum;
        res.power_sum = '0;
        res.bad_range = 1'b1;
        sum = 0;
        if (range_ok(r.left, r.right) && r.operand >= 1 && r.operand <= 3)
        begin
            for (int unsigned i = r.left - 1; i < r.right; i++)
                sum = (sum + residue_power(element_model[i], r.operand)) % MODULUS;
            res.power_sum = VAL_W'(sum);
            res.bad_range = 1'b0;
        end
        return res;
    endfunction

    function automatic void apply_update(request_row_t r);
        int unsigned c;
        int unsigned v;
        if (range_ok(r.left, r.right))
        begin
            c = r.operand % MODULUS;
            for (int unsigned i = r.left - 1; i < r.right; i++)
            begin
                v = element_model[i];
                if (r.mode == MODE_ADD)
                    v = (v + c) % MODULUS;
                else if (r.mode == MODE_MUL)
                    v = (v * c) % MODULUS;
                else
                    v = c;
                element_model[i] = VAL_W'(v);
            end
        end
    endfunction

    function automatic request_row_t random_row();
        request_row_t r;
        int unsigned  lim;
        int unsigned  span;
        int unsigned  lo;
        lim = active_limit();
        r.typed = 1'b0;
        r.exp_sum = '0;
        r.exp_bad = 1'b0;
        if ($urandom_range(0, 2) == 0)
            r.mode = MODE_QUERY;
        else
            r.mode = 2'($urandom_range(0, 2));
        if (lim == 0 || $urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                r.left = IDX_W'($urandom);
                r.right = IDX_W'($urandom);
            end
            else
            begin
                r.left = IDX_W'($urandom_range(0, lim));
                r.right = IDX_W'($urandom_range(lim, lim + 1));
            end
            r.operand = VAL_W'($urandom);
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                span = $urandom_range(1, 512);
            else
                span = $urandom_range(1, 24);
            if (span > lim)
                span = lim;
            lo = $urandom_range(1, lim - span + 1);
            r.left = IDX_W'(lo);
            r.right = IDX_W'(lo + span - 1);
            if (r.mode == MODE_QUERY)
                r.operand = ($urandom_range(0, 15) == 0) ? VAL_W'($urandom)
                                                         : VAL_W'($urandom_range(1, 3));
            else
                r.operand = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom)
                                                        : VAL_W'($urandom_range(0, MODULUS - 1));
        end
        return r;
    endfunction

    task automatic send_request(input request_row_t r);
        query_result_t want;
        start <= 1'b1;
        mode <= r.mode;
        range_left <= r.left;
        range_right <= r.right;
        operand <= r.operand;
        do
            @(posedge clk);
        while (busy);
        if (r.mode == MODE_QUERY)
        begin
            if (r.typed)
            begin
                want.power_sum = r.exp_sum;
                want.bad_range = r.exp_bad;
            end
            else
                want = power_sum_of(r);
            pending_sums.push_back(want);
            queries_sent++;
        end
        else
        begin
            apply_update(r);
            updates_sent++;
        end
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        repeat (2) @(posedge clk);
        while ((busy || pending_sums.size() != 0) && guard < 60000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_sums.size() != 0)
        begin
            $error("%0d query results never arrived", pending_sums.size());
            failures++;
            pending_sums.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                drain_results();
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    task automatic write_count(input logic [IDX_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_model = value;
        count_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected result: power_sum %0d bad_range %0d", power_sum, bad_range);
                failures++;
            end
            else
            begin
                oldest_sum = pending_sums.pop_front();
                results_checked++;
                if (power_sum !== oldest_sum.power_sum)
                begin
                    $error("power_sum: expected %0d, got %0d", oldest_sum.power_sum, power_sum);
                    failures++;
                end
                if (bad_range !== oldest_sum.bad_range)
                begin
                    $error("bad_range: expected %0d, got %0d", oldest_sum.bad_range, bad_range);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("FAIL range_update_power_sum_engine");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_ADD;
        range_left = '0;
        range_right = '0;
        operand = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        count_model = COUNT_RESET;
        for (int i = 0; i < ARRAY_SIZE; i++)
            element_model[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_count(13'd8191);
        burst_left = $urandom_range(0, 10);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_request(directed_rows[i]);
            pace_sender();
        end
        start <= 1'b0;
        drain_results();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_count(phase_counts[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                send_request(random_row());
                pace_sender();
            end
            start <= 1'b0;
            drain_results();
        end

        $display("Ran %0d updates and %0d queries (%0d results checked) over %0d count settings,",
                 updates_sent, queries_sent, results_checked, count_writes);
        $display("including full-array ranges, bad ranges, bad powers and oversized operands.");
        if (failures == 0)
            $display("PASS range_update_power_sum_engine");
        else
            $display("FAIL range_update_power_sum_engine");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rups_pkg.sv
hw/rtl/rups_mulmod.sv
hw/rtl/range_update_power_sum_engine.sv
tb/tb_range_update_power_sum_engine.sv
